FILE: sv/wmd_pkg.sv
// Package for the waveform min/max decimator: register indexes, field widths,
// reset values and the capture bundle handed from the accumulator to the emitter.
// No dependencies.
package wmd_pkg;

  localparam int SPP_W      = 24;
  localparam int CC_W       = 4;
  localparam int NP_W       = 16;
  localparam int PIDX_W     = 16;
  localparam int CHANS_W    = 5;   // holds a channel count up to 16
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_POINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS        = 2'd2;

  localparam logic [SPP_W-1:0] RST_SAMPLES_PER_POINT = 24'd1;
  localparam logic [CC_W-1:0]  RST_CHANNEL_COUNT     = 4'd2;
  localparam logic [NP_W-1:0]  RST_NUM_POINTS        = 16'd1024;

  typedef struct packed {
    logic               valid;
    logic [PIDX_W-1:0]  point_idx;
    logic [CHANS_W-1:0] chans;
  } wmd_cap_t;

endpackage

FILE: sv/wmd_emitter.sv
// Result bank and output register of the min/max decimator: holds one finished
// bucket and drains it as per-channel beats plus a final mixed beat.
// Depends on wmd_pkg.
module wmd_emitter #(
  parameter int MAX_CHANNELS = wmd_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = wmd_pkg::DEF_SAMPLE_BITS,
  parameter int CH_W         = 3
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  wmd_pkg::wmd_cap_t                       cap,
  input  logic signed [SAMPLE_BITS-1:0]           cap_min [MAX_CHANNELS],
  input  logic        [SAMPLE_BITS-2:0]           cap_max [MAX_CHANNELS],
  output logic                                    busy,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [wmd_pkg::PIDX_W-1:0]              out_point_index,
  output logic [CH_W-1:0]                         out_channel,
  output logic                                    out_is_mix,
  output logic signed [SAMPLE_BITS-1:0]           out_min_value,
  output logic [SAMPLE_BITS-2:0]                  out_max_value,
  output logic                                    out_last
);
  import wmd_pkg::*;

  logic                          busy_r;
  logic [CHANS_W-1:0]            idx_r;
  logic [CHANS_W-1:0]            chans_r;
  logic [PIDX_W-1:0]             pidx_r;
  logic signed [SAMPLE_BITS-1:0] snap_min_r [MAX_CHANNELS];
  logic [SAMPLE_BITS-2:0]        snap_max_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] mix_min_r;
  logic [SAMPLE_BITS-2:0]        mix_max_r;

  logic                          out_valid_r;
  logic [PIDX_W-1:0]             out_pidx_r;
  logic [CH_W-1:0]               out_ch_r;
  logic                          out_mix_r;
  logic signed [SAMPLE_BITS-1:0] out_min_r;
  logic [SAMPLE_BITS-2:0]        out_max_r;

  logic                          load;
  logic                          mix_beat;
  logic [CH_W-1:0]               sel;
  logic signed [SAMPLE_BITS-1:0] cur_min;
  logic [SAMPLE_BITS-2:0]        cur_max;
  logic signed [SAMPLE_BITS-1:0] mix_min_nxt;
  logic [SAMPLE_BITS-2:0]        mix_max_nxt;

  assign load     = busy_r && (!out_valid_r || out_ready);
  assign mix_beat = (idx_r == chans_r);
  assign sel      = mix_beat ? '0 : idx_r[CH_W-1:0];
  assign cur_min  = snap_min_r[sel];
  assign cur_max  = snap_max_r[sel];

  assign mix_min_nxt = (cur_min < mix_min_r) ? cur_min : mix_min_r;
  assign mix_max_nxt = (cur_max > mix_max_r) ? cur_max : mix_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cap.valid) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load) begin
        if (mix_beat) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Bank and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (cap.valid) begin
      chans_r    <= cap.chans;
      pidx_r     <= cap.point_idx;
      snap_min_r <= cap_min;
      snap_max_r <= cap_max;
      mix_min_r  <= '0;
      mix_max_r  <= '0;
    end else if (load && !mix_beat) begin
      mix_min_r <= mix_min_nxt;
      mix_max_r <= mix_max_nxt;
    end
    if (load) begin
      out_pidx_r <= pidx_r;
      if (mix_beat) begin
        out_ch_r  <= '0;
        out_mix_r <= 1'b1;
        out_min_r <= mix_min_r;
        out_max_r <= mix_max_r;
      end else begin
        out_ch_r  <= idx_r[CH_W-1:0];
        out_mix_r <= 1'b0;
        out_min_r <= cur_min;
        out_max_r <= cur_max;
      end
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_point_index = out_pidx_r;
  assign out_channel     = out_ch_r;
  assign out_is_mix      = out_mix_r;
  assign out_min_value   = out_min_r;
  assign out_max_value   = out_max_r;
  assign out_last        = out_mix_r;

endmodule

FILE: sv/waveform_minmax_decimator_unit.sv
// Top level of the waveform min/max decimator: configuration registers, per-channel
// running min/max accumulators and bucket counters; drains through wmd_emitter.
// Depends on wmd_pkg and wmd_emitter.
//
// Takes one interleaved Q1.15 sample per cycle while in_ready is high and folds
// it into its channel's running min/max in the same cycle. The sample that ends
// a bucket copies all channels into a result bank, which then sends channel_count
// per-channel beats and one mixed beat (last = 1), one beat per cycle while
// out_ready is high. Accumulation of the next bucket runs while the bank drains;
// only the sample that ends a bucket waits (in_ready low) if the bank still holds
// the previous bucket. The bank frees when its mixed beat is loaded into the
// output register. After num_points buckets all samples are accepted and dropped
// until reset.
module waveform_minmax_decimator_unit #(
  parameter int MAX_CHANNELS = wmd_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = wmd_pkg::DEF_SAMPLE_BITS,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wmd_pkg::PIDX_W-1:0]        out_point_index,
  output logic [CH_W-1:0]                   out_channel,
  output logic                              out_is_mix,
  output logic signed [SAMPLE_BITS-1:0]     out_min_value,
  output logic [SAMPLE_BITS-2:0]            out_max_value,
  output logic                              out_last
);
  import wmd_pkg::*;

  localparam logic [CHANS_W-1:0] MAX_CH_V = CHANS_W'(MAX_CHANNELS);

  logic [SPP_W-1:0] spp_r;
  logic [CC_W-1:0]  cc_r;
  logic [NP_W-1:0]  np_r;

  logic signed [SAMPLE_BITS-1:0] acc_min_r   [MAX_CHANNELS];
  logic [SAMPLE_BITS-2:0]        acc_max_r   [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] acc_min_nxt [MAX_CHANNELS];
  logic [SAMPLE_BITS-2:0]        acc_max_nxt [MAX_CHANNELS];
  logic [SPP_W-1:0]              frame_cnt_r;
  logic [CH_W-1:0]               ch_r;
  logic [PIDX_W-1:0]             point_cnt_r;
  logic [PIDX_W-1:0]             point_cnt_nxt;
  logic                          finished_r;

  logic [CHANS_W-1:0] cc_ext;
  logic [CHANS_W-1:0] chans_eff;
  logic [CHANS_W-1:0] last_ch;
  logic [CHANS_W-1:0] ch_ext;
  logic [CHANS_W-1:0] ch_sel;
  logic [CH_W-1:0]    ch_idx;
  logic [SPP_W-1:0]   spp_eff;
  logic               frame_end;
  logic               frame_last_ch;
  logic               done;
  logic               bucket_end;
  logic               accept;
  logic               take;
  logic               emit_busy;
  wmd_cap_t           cap;

  // Clamp configuration to usable ranges.
  assign cc_ext    = CHANS_W'(cc_r);
  assign chans_eff = (cc_ext == '0) ? CHANS_W'(1) :
                     (cc_ext > MAX_CH_V) ? MAX_CH_V : cc_ext;
  assign last_ch   = chans_eff - 1'b1;
  assign ch_ext    = CHANS_W'(ch_r);
  assign ch_sel    = (ch_ext >= chans_eff) ? last_ch : ch_ext;
  assign ch_idx    = ch_sel[CH_W-1:0];
  assign spp_eff   = (spp_r == '0) ? SPP_W'(1) : spp_r;

  assign frame_last_ch = (ch_sel == last_ch);
  assign frame_end     = ({1'b0, frame_cnt_r} + (SPP_W+1)'(1)) >= {1'b0, spp_eff};
  assign done          = finished_r || (point_cnt_r >= np_r);
  assign bucket_end    = !done && frame_last_ch && frame_end;

  // Hold only the bucket-ending sample while the bank is still draining.
  assign in_ready = !(bucket_end && emit_busy);
  assign accept   = in_valid && in_ready;
  assign take     = accept && !done;

  assign point_cnt_nxt = point_cnt_r + 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      acc_min_nxt[i] = acc_min_r[i];
      acc_max_nxt[i] = acc_max_r[i];
      if (CH_W'(i) == ch_idx) begin
        if (in_sample < acc_min_r[i]) begin
          acc_min_nxt[i] = in_sample;
        end
        if (in_sample > $signed({1'b0, acc_max_r[i]})) begin
          acc_max_nxt[i] = in_sample[SAMPLE_BITS-2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r       <= RST_SAMPLES_PER_POINT;
      cc_r        <= RST_CHANNEL_COUNT;
      np_r        <= RST_NUM_POINTS;
      frame_cnt_r <= '0;
      ch_r        <= '0;
      point_cnt_r <= '0;
      finished_r  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        acc_min_r[i] <= '0;
        acc_max_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_POINT: spp_r <= cfg_wdata[SPP_W-1:0];
          REG_CHANNEL_COUNT:     cc_r  <= cfg_wdata[CC_W-1:0];
          REG_NUM_POINTS:        np_r  <= cfg_wdata[NP_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        if (!frame_last_ch) begin
          ch_r <= CH_W'(ch_sel + 1'b1);
        end else begin
          ch_r <= '0;
        end
        if (bucket_end) begin
          frame_cnt_r <= '0;
          point_cnt_r <= point_cnt_nxt;
          if ((point_cnt_nxt >= np_r) || (point_cnt_nxt == '0)) begin
            finished_r <= 1'b1;
          end
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            acc_min_r[i] <= '0;
            acc_max_r[i] <= '0;
          end
        end else begin
          if (frame_last_ch) begin
            frame_cnt_r <= frame_cnt_r + 1'b1;
          end
          acc_min_r <= acc_min_nxt;
          acc_max_r <= acc_max_nxt;
        end
      end
    end
  end

  assign cap.valid     = take && bucket_end;
  assign cap.point_idx = point_cnt_r;
  assign cap.chans     = chans_eff;

  wmd_emitter #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CH_W         (CH_W)
  ) u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .cap             (cap),
    .cap_min         (acc_min_nxt),
    .cap_max         (acc_max_nxt),
    .busy            (emit_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_index (out_point_index),
    .out_channel     (out_channel),
    .out_is_mix      (out_is_mix),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value),
    .out_last        (out_last)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cap.valid |-> !emit_busy)
    else $error("bucket captured while result bank still draining");

  a_capture_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cap.valid |=> emit_busy)
    else $error("result bank not busy after capture");

  a_no_capture_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !cap.valid)
    else $error("bucket captured after point limit");

  a_mix_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_mix) |-> (out_last && (out_channel == '0) &&
                                   (out_min_value <= 0)))
    else $error("mixed beat malformed");

endmodule
